// ===== src/stk_pkg.sv =====
`default_nettype none

package stk_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int CAP_W         = 6;
    localparam int DEPTH_DEFAULT = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
    localparam logic [OP_W-1:0] OP_POP         = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK        = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP_TOP    = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP_BOTTOM = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
        logic load_top;
        logic load_bottom;
        logic rd_en;
        logic step_up;
        logic step_down;
        logic out_load;
        logic out_last;
    } stk_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic at_bottom;
        logic at_top;
        logic out_free;
    } stk_status_t;

endpackage

`default_nettype wire

// ===== src/bounded_integer_stack.sv =====
`default_nettype none

// Bounded LIFO stack of signed 32-bit integers held in a single-port-write,
// registered-read memory of DEPTH words. Push and pop give no item; pushes
// are dropped once the stack holds min(capacity, DEPTH) entries, pops are
// dropped when empty. Peek and both dump orders read the memory one entry
// at a time: each returned item takes an address issue, then a load of the
// output register, which waits while the output register is full and
// m_tready is low. s_tready is low from after the accepting cycle until the
// last item is loaded. The last item of a dump and every peek item carry
// m_tlast. The capacity register is written through cfg_valid/cfg_data,
// always ready, and resets to 32.

module bounded_integer_stack #(
    parameter int DEPTH = stk_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [stk_pkg::CAP_W-1:0]   cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,   // opcode[2:0], value[34:3], zero pad
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [stk_pkg::DATA_W-1:0]       m_tdata,   // data[31:0]
    output logic                             m_tlast
);
    import stk_pkg::*;

    stk_cmd_t          cmd;
    stk_status_t       st;
    logic [OP_W-1:0]   s_opcode;
    logic [DATA_W-1:0] s_value;

    assign cfg_ready = 1'b1;
    assign s_opcode  = s_tdata[OP_W-1:0];
    assign s_value   = s_tdata[OP_W+DATA_W-1:OP_W];

    stk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_opcode),
        .st       (st),
        .cmd      (cmd)
    );

    stk_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .value     (s_value),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !st.full)
        else $error("push into full stack");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.push, cmd.pop, cmd.load_top, cmd.load_bottom, cmd.rd_en,
                  cmd.out_load}))
        else $error("conflicting datapath commands");

    a_peek_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_opcode == OP_PEEK && !st.empty) |=> !s_tready)
        else $error("peek did not hold off input");

endmodule

`default_nettype wire

// ===== src/stk_ctrl.sv =====
`default_nettype none

module stk_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [stk_pkg::OP_W-1:0]  opcode,
    input  wire stk_pkg::stk_status_t      st,
    output stk_pkg::stk_cmd_t              cmd
);
    import stk_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        MODE_PEEK,
        MODE_DOWN,
        MODE_UP
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   accept;
    logic   last_item;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        last_item  = 1'b0;
        unique case (mode_reg)
            MODE_PEEK: last_item = 1'b1;
            MODE_DOWN: last_item = st.at_bottom;
            MODE_UP:   last_item = st.at_top;
            default:   last_item = 1'b1;
        endcase
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (opcode)
                        OP_PUSH: cmd.push = !st.full;
                        OP_POP:  cmd.pop  = !st.empty;
                        OP_PEEK: begin
                            if (!st.empty) begin
                                cmd.load_top = 1'b1;
                                mode_next    = MODE_PEEK;
                                state_next   = ST_READ;
                            end
                        end
                        OP_DUMP_TOP: begin
                            if (!st.empty) begin
                                cmd.load_top = 1'b1;
                                mode_next    = MODE_DOWN;
                                state_next   = ST_READ;
                            end
                        end
                        OP_DUMP_BOTTOM: begin
                            if (!st.empty) begin
                                cmd.load_bottom = 1'b1;
                                mode_next       = MODE_UP;
                                state_next      = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = last_item;
                    if (last_item) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step_up   = (mode_reg == MODE_UP);
                        cmd.step_down = (mode_reg == MODE_DOWN);
                        state_next    = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_PEEK;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/stk_datapath.sv =====
`default_nettype none

module stk_datapath #(
    parameter int DEPTH = stk_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic [stk_pkg::CAP_W-1:0]   cfg_data,
    input  wire logic [stk_pkg::DATA_W-1:0]  value,
    input  wire stk_pkg::stk_cmd_t           cmd,
    output stk_pkg::stk_status_t             st,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [stk_pkg::DATA_W-1:0]       m_tdata,
    output logic                             m_tlast
);
    import stk_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  top_idx;
    logic [CMP_W-1:0]  eff_cap;

    assign top_idx = count_reg - CNT_W'(1);
    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);

    assign st.empty     = (count_reg == '0);
    assign st.full      = (CMP_W'(count_reg) >= eff_cap);
    assign st.at_bottom = (idx_reg == '0);
    assign st.at_top    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_top) begin
            idx_next = top_idx[IDX_W-1:0];
        end else if (cmd.load_bottom) begin
            idx_next = '0;
        end else if (cmd.step_up) begin
            idx_next = idx_reg + IDX_W'(1);
        end else if (cmd.step_down) begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[count_reg[IDX_W-1:0]] <= value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.out_load) begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= cmd.out_last;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    import stk_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_CYCLES = 600000;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              tlast;
    } stack_word_t;

    typedef enum {RX_STREAM, RX_LIGHT, RX_HALF, RX_LONG} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // opcode[2:0], value[34:3], zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;   // data[31:0]
    logic                 m_tlast;

    // predictor state
    logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
    int                   stack_count;
    logic [CAP_W-1:0]     cap_reg;
    stack_word_t          expected_words [$];
    stack_word_t          head_word;

    int                   failures;
    int                   burst_left;
    rx_mode_t             rx_mode;
    int                   rx_tick;
    int                   rx_hold;

    bounded_integer_stack dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * TIMEOUT_CYCLES);
        $display("bounded_integer_stack: mismatch");
        $finish;
    end

    // apply one accepted item to the stack image and queue what it returns
    function automatic bit stack_apply(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        int eff_cap;
        bit acted;
        stack_word_t w;
        eff_cap = (int'(cap_reg) > STACK_DEPTH) ? STACK_DEPTH : int'(cap_reg);
        acted = 1'b0;
        case (op)
            OP_PUSH: begin
                if (stack_count < eff_cap) begin
                    stack_mem[stack_count] = value;
                    stack_count++;
                    acted = 1'b1;
                end
            end
            OP_POP: begin
                if (stack_count > 0) begin
                    stack_count--;
                    acted = 1'b1;
                end
            end
            OP_PEEK: begin
                if (stack_count > 0) begin
                    w.data  = stack_mem[stack_count-1];
                    w.tlast = 1'b1;
                    expected_words.push_back(w);
                    acted = 1'b1;
                end
            end
            OP_DUMP_TOP: begin
                for (int i = stack_count; i > 0; i--) begin
                    w.data  = stack_mem[i-1];
                    w.tlast = (i == 1);
                    expected_words.push_back(w);
                    acted = 1'b1;
                end
            end
            OP_DUMP_BOTTOM: begin
                for (int i = 0; i < stack_count; i++) begin
                    w.data  = stack_mem[i];
                    w.tlast = (i + 1 == stack_count);
                    expected_words.push_back(w);
                    acted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return acted;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                             output bit acted);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        acted = stack_apply(op, value);
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        bit acted;
        send_item(op, value, acted);
    endtask

    // hold off the sender until every queued item has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cap_reg = cap;
    endtask

    function automatic logic [DATA_W-1:0] random_word;
        case ($urandom_range(0, 4))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return $urandom_range(0, 15);
            3: return -$urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] random_op(input int push_pct);
        int r;
        if ($urandom_range(0, 99) < push_pct) return OP_PUSH;
        r = $urandom_range(0, 19);
        if (r < 7) return OP_POP;
        if (r < 11) return OP_PEEK;
        if (r < 14) return OP_DUMP_TOP;
        if (r < 17) return OP_DUMP_BOTTOM;
        return OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    endfunction

    task automatic test_empty_stack;
        send(OP_POP, $urandom);
        send(OP_PEEK, $urandom);
        send(OP_DUMP_TOP, $urandom);
        send(OP_DUMP_BOTTOM, $urandom);
        send(OP_UNUSED_FIRST, $urandom);
        send(OP_UNUSED_LAST, $urandom);
    endtask

    task automatic test_value_extremes;
        send(OP_PUSH, WORD_MIN);
        send(OP_PUSH, WORD_MAX);
        send(OP_PUSH, '0);
        send(OP_PUSH, '1);
        send(OP_PEEK, '0);
        send(OP_DUMP_TOP, '0);
        send(OP_DUMP_BOTTOM, '1);
        send(OP_POP, '0);
    endtask

    task automatic test_capacity_limits;
        // capacity below the current fill
        write_capacity(6'd2);
        send(OP_PUSH, $urandom);
        send(OP_DUMP_TOP, '0);
        send(OP_POP, '0);
        send(OP_POP, '0);
        send(OP_PUSH, $urandom);
        send(OP_PUSH, $urandom);
        send(OP_DUMP_BOTTOM, '0);
        // zero capacity drops every push
        write_capacity(6'd0);
        send(OP_PUSH, $urandom);
        send(OP_PEEK, '0);
        send(OP_POP, '0);
        // capacity above depth is clamped
        write_capacity(6'd63);
        send(OP_PUSH, $urandom);
        send(OP_PEEK, '0);
    endtask

    task automatic random_phase(input logic [CAP_W-1:0] cap, input int push_pct,
                                input int target);
        write_capacity(cap);
        repeat (target) begin
            send(random_op(push_pct), random_word());
        end
    endtask

    task automatic test_random_traffic;
        random_phase(6'd1, 50, 54);
        random_phase(6'd32, 75, 54);
        random_phase(6'd63, 70, 54);
        random_phase(6'd5, 45, 54);
        random_phase(6'd40, 60, 54);
        random_phase(6'd17, 55, 54);
        random_phase(6'd32, 40, 54);
        random_phase(6'd2, 50, 54);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected item: data expected none actual %h", m_tdata);
                failures++;
            end else begin
                head_word = expected_words.pop_front();
                if (m_tdata !== head_word.data) begin
                    $error("data: expected %h actual %h", head_word.data, m_tdata);
                    failures++;
                end
                if (m_tlast !== head_word.tlast) begin
                    $error("last: expected %b actual %b", head_word.tlast, m_tlast);
                    failures++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else begin
                    rx_hold = $urandom_range(0, 8);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    initial begin
        failures    = 0;
        burst_left  = 0;
        rx_mode     = RX_STREAM;
        rx_tick     = 0;
        rx_hold     = 0;
        stack_count = 0;
        cap_reg     = CAP_RESET;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_empty_stack();
        test_value_extremes();
        test_capacity_limits();
        test_random_traffic();

        drain();
        if (failures == 0) begin
            $display("bounded_integer_stack: match");
        end else begin
            $display("bounded_integer_stack: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
